### hw/rtl/bafc_pkg.sv
package bafc_pkg;

  // fixed field widths of the event and the register file
  localparam int COL_W      = 9;
  localparam int ROW_W      = 9;
  localparam int SUPPORT_W  = 6;
  localparam int RADIUS_W   = 2;
  localparam int WINDOW_W   = 31;
  localparam int SIZE_W     = 10;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 5;

  // signed width for window coordinates and clipping compares
  localparam int COORD_W = 14;

  // register indexes, byte address is four times the index
  typedef enum logic [2:0] {
    REG_MIN_SUPPORT   = 3'd0,
    REG_RADIUS        = 3'd1,
    REG_TIME_WINDOW   = 3'd2,
    REG_USE_POLARITY  = 3'd3,
    REG_ACTIVE_WIDTH  = 3'd4,
    REG_ACTIVE_HEIGHT = 3'd5
  } reg_index_t;

  // reset values of the registers
  localparam logic [SUPPORT_W-1:0] MIN_SUPPORT_RST   = 6'd1;
  localparam logic [RADIUS_W-1:0]  RADIUS_RST        = 2'd1;
  localparam logic [WINDOW_W-1:0]  TIME_WINDOW_RST   = 31'd10000;
  localparam logic                 USE_POLARITY_RST  = 1'b0;
  localparam logic [SIZE_W-1:0]    ACTIVE_WIDTH_RST  = 10'd512;
  localparam logic [SIZE_W-1:0]    ACTIVE_HEIGHT_RST = 10'd512;

  // register file contents as seen by the sequencer
  typedef struct packed {
    logic [SUPPORT_W-1:0] min_support;
    logic [RADIUS_W-1:0]  radius;
    logic [WINDOW_W-1:0]  time_window;
    logic                 use_polarity;
    logic [SIZE_W-1:0]    active_width;
    logic [SIZE_W-1:0]    active_height;
  } cfg_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_RESP
  } seq_state_t;

endpackage

### hw/rtl/bafc_cfg.sv
module bafc_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [bafc_pkg::APB_ADDR_W-1:0]  cfg_paddr,
  input  logic [bafc_pkg::APB_DATA_W-1:0]  cfg_pwdata,
  output logic [bafc_pkg::APB_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready,
  output bafc_pkg::cfg_t                   cfg
);
  import bafc_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  reg_index_t reg_idx;
  logic       wr_en;

  assign cfg_pready = 1'b1;
  assign reg_idx    = reg_index_t'(cfg_paddr[APB_ADDR_W-1:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg        = cfg_r;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_MIN_SUPPORT:   cfg_nxt.min_support   = cfg_pwdata[SUPPORT_W-1:0];
        REG_RADIUS:        cfg_nxt.radius        = cfg_pwdata[RADIUS_W-1:0];
        REG_TIME_WINDOW:   cfg_nxt.time_window   = cfg_pwdata[WINDOW_W-1:0];
        REG_USE_POLARITY:  cfg_nxt.use_polarity  = cfg_pwdata[0];
        REG_ACTIVE_WIDTH:  cfg_nxt.active_width  = cfg_pwdata[SIZE_W-1:0];
        REG_ACTIVE_HEIGHT: cfg_nxt.active_height = cfg_pwdata[SIZE_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  // read mux, unmapped addresses read zero
  always_comb begin
    cfg_prdata = '0;
    unique case (reg_idx)
      REG_MIN_SUPPORT:   cfg_prdata = APB_DATA_W'(cfg_r.min_support);
      REG_RADIUS:        cfg_prdata = APB_DATA_W'(cfg_r.radius);
      REG_TIME_WINDOW:   cfg_prdata = APB_DATA_W'(cfg_r.time_window);
      REG_USE_POLARITY:  cfg_prdata = APB_DATA_W'(cfg_r.use_polarity);
      REG_ACTIVE_WIDTH:  cfg_prdata = APB_DATA_W'(cfg_r.active_width);
      REG_ACTIVE_HEIGHT: cfg_prdata = APB_DATA_W'(cfg_r.active_height);
      default:           cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_support   <= MIN_SUPPORT_RST;
      cfg_r.radius        <= RADIUS_RST;
      cfg_r.time_window   <= TIME_WINDOW_RST;
      cfg_r.use_polarity  <= USE_POLARITY_RST;
      cfg_r.active_width  <= ACTIVE_WIDTH_RST;
      cfg_r.active_height <= ACTIVE_HEIGHT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### hw/rtl/bafc_pixel_store.sv
module bafc_pixel_store #(
  parameter int DEPTH = 262144,
  parameter int AW    = 18,
  parameter int DW    = 65
) (
  input  logic          clk,
  input  logic          we,
  input  logic          re,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  // one word per pixel: stored polarity on top, stored time below
  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

endmodule

### hw/rtl/bafc_match.sv
module bafc_match #(
  parameter int TIME_BITS = 64
) (
  input  logic                              rd_valid,
  input  logic                              stored_pol,
  input  logic [TIME_BITS-1:0]              stored_time,
  input  logic                              evt_pol,
  input  logic [TIME_BITS-1:0]              evt_time,
  input  logic                              use_polarity,
  input  logic [bafc_pkg::WINDOW_W-1:0]     time_window,
  output logic                              hit
);
  import bafc_pkg::*;

  localparam int CMP_W = (TIME_BITS > WINDOW_W) ? TIME_BITS : WINDOW_W;

  logic [TIME_BITS-1:0] age;
  logic                 recent;
  logic                 pol_ok;

  // age wraps modulo the time width
  assign age    = evt_time - stored_time;
  assign recent = CMP_W'(age) <= CMP_W'(time_window);
  assign pol_ok = !use_polarity || (stored_pol == evt_pol);

  // an off event stored at a pixel never supports
  assign hit = rd_valid && stored_pol && pol_ok && recent;

endmodule

### hw/rtl/bafc_seq.sv
module bafc_seq #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int MAX_RADIUS = 3,
  parameter int TIME_BITS  = 64,
  parameter int DEPTH      = 262144,
  parameter int AW         = 18
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bafc_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [TIME_BITS-1:0]          in_timestamp,
  input  logic [bafc_pkg::COL_W-1:0]    in_col,
  input  logic [bafc_pkg::ROW_W-1:0]    in_row,
  input  logic                          in_polarity,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_keep,
  output logic                          mem_we,
  output logic                          mem_re,
  output logic [AW-1:0]                 mem_addr,
  output logic [TIME_BITS:0]            mem_wdata,
  output logic                          rd_valid,
  output logic                          evt_pol,
  output logic [TIME_BITS-1:0]          evt_time,
  input  logic                          hit
);
  import bafc_pkg::*;

  localparam int RW     = $clog2(MAX_RADIUS + 1) + 1;
  localparam int CELLS  = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int CNT_W  = $clog2(CELLS + 1);
  localparam int KCMP_W = (CNT_W > SUPPORT_W) ? CNT_W : SUPPORT_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  seq_state_t state_r, state_nxt;

  logic [AW-1:0]          clr_addr_r, clr_addr_nxt;
  logic                   rd_pend_r, rd_pend_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_keep_r, out_keep_nxt;
  logic [TIME_BITS-1:0]   ts_r, ts_nxt;
  logic [COL_W-1:0]       col_r, col_nxt;
  logic [ROW_W-1:0]       row_r, row_nxt;
  logic                   pol_r, pol_nxt;
  logic                   outside_r, outside_nxt;
  logic signed [RW-1:0]   rad_r, rad_nxt;
  logic signed [RW-1:0]   dx_r, dx_nxt;
  logic signed [RW-1:0]   dy_r, dy_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;

  logic signed [COORD_W-1:0] w_lim, h_lim;
  logic signed [COORD_W-1:0] cell_x, cell_y;
  logic signed [COORD_W-1:0] in_x, in_y;
  logic signed [RW-1:0]      rad_sat;
  logic                      outside_in;
  logic                      cell_inside;
  logic                      last_cell;
  logic                      accept;
  logic                      out_load;
  logic                      keep_calc;
  logic [AW-1:0]             cell_addr;
  logic [AW-1:0]             evt_addr;
  logic [CNT_W-1:0]          count_acc;

  // active area and radius clamped to the built maximum
  assign w_lim = ({{(COORD_W-SIZE_W){1'b0}}, cfg.active_width} > COORD_W'(MAX_WIDTH)) ?
                 COORD_W'(MAX_WIDTH) : {{(COORD_W-SIZE_W){1'b0}}, cfg.active_width};
  assign h_lim = ({{(COORD_W-SIZE_W){1'b0}}, cfg.active_height} > COORD_W'(MAX_HEIGHT)) ?
                 COORD_W'(MAX_HEIGHT) : {{(COORD_W-SIZE_W){1'b0}}, cfg.active_height};
  assign rad_sat = (32'(cfg.radius) > 32'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(cfg.radius);

  // incoming event position check
  assign in_x       = {{(COORD_W-COL_W){1'b0}}, in_col};
  assign in_y       = {{(COORD_W-ROW_W){1'b0}}, in_row};
  assign outside_in = (in_x >= w_lim) || (in_y >= h_lim);

  // current window cell, clipped at the sensor edges
  assign cell_x = signed'({{(COORD_W-COL_W){1'b0}}, col_r}) + COORD_W'(dx_r);
  assign cell_y = signed'({{(COORD_W-ROW_W){1'b0}}, row_r}) + COORD_W'(dy_r);
  assign cell_inside = (cell_x >= 0) && (cell_x < w_lim) && (cell_y >= 0) && (cell_y < h_lim);
  assign last_cell   = (dx_r == rad_r) && (dy_r == rad_r);

  // pixel addresses, row major at the built width
  assign cell_addr = AW'(unsigned'(cell_y)) * AW'(MAX_WIDTH) + AW'(unsigned'(cell_x));
  assign evt_addr  = AW'(row_r) * AW'(MAX_WIDTH) + AW'(col_r);

  assign count_acc = count_r + CNT_W'(hit);
  assign keep_calc = !outside_r && (KCMP_W'(count_r) >= KCMP_W'(cfg.min_support));

  assign rd_valid  = rd_pend_r;
  assign evt_pol   = pol_r;
  assign evt_time  = ts_r;
  assign out_valid = out_valid_r;
  assign out_keep  = out_keep_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (clr_addr_r == LAST_ADDR) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_valid) state_nxt = outside_in ? ST_RESP : ST_SCAN;
      ST_SCAN:   if (last_cell) state_nxt = ST_FINISH;
      ST_FINISH: state_nxt = ST_RESP;
      ST_RESP:   if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // state outputs: handshake and store port
  always_comb begin
    in_stall  = 1'b1;
    accept    = 1'b0;
    out_load  = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = cell_addr;
    mem_wdata = {pol_r, ts_r};
    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_addr_r;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        accept   = in_valid;
      end
      ST_SCAN: begin
        mem_re = cell_inside;
      end
      ST_FINISH: begin
        mem_we   = 1'b1;
        mem_addr = evt_addr;
      end
      ST_RESP: begin
        out_load = !out_valid_r || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // datapath next values
  always_comb begin
    clr_addr_nxt  = clr_addr_r;
    ts_nxt        = ts_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    pol_nxt       = pol_r;
    outside_nxt   = outside_r;
    rad_nxt       = rad_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    count_nxt     = count_r;
    rd_pend_nxt   = (state_r == ST_SCAN) && cell_inside;
    out_keep_nxt  = out_load ? keep_calc : out_keep_r;
    out_valid_nxt = out_load ? 1'b1 : (out_valid_r && out_stall);

    if (state_r == ST_CLEAR) begin
      clr_addr_nxt = clr_addr_r + AW'(1);
    end

    // capture the event and start the window at its top left corner
    if (accept) begin
      ts_nxt      = in_timestamp;
      col_nxt     = in_col;
      row_nxt     = in_row;
      pol_nxt     = in_polarity;
      outside_nxt = outside_in;
      rad_nxt     = rad_sat;
      dx_nxt      = -rad_sat;
      dy_nxt      = -rad_sat;
      count_nxt   = '0;
    end

    // walk the window column by column, counting last cycle's read
    if (state_r == ST_SCAN) begin
      count_nxt = count_acc;
      if (dy_r == rad_r) begin
        dy_nxt = -rad_r;
        dx_nxt = dx_r + RW'(1);
      end else begin
        dy_nxt = dy_r + RW'(1);
      end
    end

    // final read lands while the event is written back
    if (state_r == ST_FINISH) begin
      count_nxt = count_acc;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_keep_r <= out_keep_nxt;
    ts_r       <= ts_nxt;
    col_r      <= col_nxt;
    row_r      <= row_nxt;
    pol_r      <= pol_nxt;
    outside_r  <= outside_nxt;
    rad_r      <= rad_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    count_r    <= count_nxt;
  end

endmodule

### hw/rtl/event_background_activity_filter_core.sv
// channel  | handshake                          | payload
// ---------+------------------------------------+----------------------------------
// in_      | in_valid / in_stall                | in_timestamp, in_col, in_row,
//          |                                    | in_polarity
// out_     | out_valid / out_stall              | out_keep
// cfg_     | cfg_psel, cfg_penable, cfg_pwrite, | cfg_paddr, cfg_pwdata, cfg_prdata
//          | cfg_pready                         |
//
// an event inside the active area passes an accept state, one scan step per window cell with a
// pixel store read on the single store port for each cell inside the area, a write back state
// and a result state; an event outside the area goes from accept to result and touches no pixel
// after reset a clearing pass writes every pixel, MAX_WIDTH*MAX_HEIGHT of them (262144),
// during which input stays stalled; configuration writes are taken meanwhile
// the result sits in an output register, so a stalled result only blocks the next one
module event_background_activity_filter_core #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int MAX_RADIUS = 3,
  parameter int TIME_BITS  = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [TIME_BITS-1:0]             in_timestamp,
  input  logic [bafc_pkg::COL_W-1:0]       in_col,
  input  logic [bafc_pkg::ROW_W-1:0]       in_row,
  input  logic                             in_polarity,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_keep,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [bafc_pkg::APB_ADDR_W-1:0]  cfg_paddr,
  input  logic [bafc_pkg::APB_DATA_W-1:0]  cfg_pwdata,
  output logic [bafc_pkg::APB_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready
);
  import bafc_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DW    = TIME_BITS + 1;

  cfg_t                 cfg;
  logic                 mem_we;
  logic                 mem_re;
  logic [AW-1:0]        mem_addr;
  logic [DW-1:0]        mem_wdata;
  logic [DW-1:0]        mem_rdata;
  logic                 rd_valid;
  logic                 evt_pol;
  logic [TIME_BITS-1:0] evt_time;
  logic                 hit;

  // register file
  bafc_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // per pixel polarity and time
  bafc_pixel_store #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (DW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // shared neighbour test, one stored pixel per cycle
  bafc_match #(
    .TIME_BITS (TIME_BITS)
  ) u_match (
    .rd_valid     (rd_valid),
    .stored_pol   (mem_rdata[DW-1]),
    .stored_time  (mem_rdata[TIME_BITS-1:0]),
    .evt_pol      (evt_pol),
    .evt_time     (evt_time),
    .use_polarity (cfg.use_polarity),
    .time_window  (cfg.time_window),
    .hit          (hit)
  );

  // window sequencer
  bafc_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS),
    .TIME_BITS  (TIME_BITS),
    .DEPTH      (DEPTH),
    .AW         (AW)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_timestamp (in_timestamp),
    .in_col       (in_col),
    .in_row       (in_row),
    .in_polarity  (in_polarity),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_keep     (out_keep),
    .mem_we       (mem_we),
    .mem_re       (mem_re),
    .mem_addr     (mem_addr),
    .mem_wdata    (mem_wdata),
    .rd_valid     (rd_valid),
    .evt_pol      (evt_pol),
    .evt_time     (evt_time),
    .hit          (hit)
  );

`ifndef SYNTHESIS
  // an accepted transaction holds off the next one while the window is scanned
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after an accepted transaction");

  // the single store port never reads and writes in one cycle
  a_store_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("pixel store read and write in the same cycle");

  // the clearing pass after reset keeps input stalled
  a_clear_stalls: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input taken before the pixel store was cleared");
`endif

endmodule

### tb/sv/testbench.sv
module testbench;
  import bafc_pkg::*;

  localparam int COLS_MAX    = 512;
  localparam int ROWS_MAX    = 512;
  localparam int RADIUS_MAX  = 3;
  localparam int PIXELS      = COLS_MAX * ROWS_MAX;
  // the limit also covers the clearing pass after reset, which moves no transaction
  localparam int QUIET_LIMIT = 800000;
  localparam int TAIL_CYCLES = 80;
  localparam int HOLD_LONG   = 400;

  // per-pixel event memory, filter settings and the keep decisions still to come
  class filter_scoreboard;
    bit                   pix_pol  [PIXELS];
    bit [63:0]            pix_time [PIXELS];
    logic [SUPPORT_W-1:0] support   = MIN_SUPPORT_RST;
    logic [RADIUS_W-1:0]  radius    = RADIUS_RST;
    logic [WINDOW_W-1:0]  window    = TIME_WINDOW_RST;
    logic                 pol_match = USE_POLARITY_RST;
    logic [SIZE_W-1:0]    cols_reg  = ACTIVE_WIDTH_RST;
    logic [SIZE_W-1:0]    rows_reg  = ACTIVE_HEIGHT_RST;
    bit                   keep_due [$];
    int unsigned          events;
    int unsigned          results;
    int unsigned          kept;
    int unsigned          errors;

    function int limit(int v, int top);
      return (v > top) ? top : v;
    endfunction

    function void set_reg(reg_index_t idx, logic [APB_DATA_W-1:0] v);
      case (idx)
        REG_MIN_SUPPORT:   support   = v[SUPPORT_W-1:0];
        REG_RADIUS:        radius    = v[RADIUS_W-1:0];
        REG_TIME_WINDOW:   window    = v[WINDOW_W-1:0];
        REG_USE_POLARITY:  pol_match = v[0];
        REG_ACTIVE_WIDTH:  cols_reg  = v[SIZE_W-1:0];
        REG_ACTIVE_HEIGHT: rows_reg  = v[SIZE_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [APB_DATA_W-1:0] reg_value(reg_index_t idx);
      case (idx)
        REG_MIN_SUPPORT:   return APB_DATA_W'(support);
        REG_RADIUS:        return APB_DATA_W'(radius);
        REG_TIME_WINDOW:   return APB_DATA_W'(window);
        REG_USE_POLARITY:  return APB_DATA_W'(pol_match);
        REG_ACTIVE_WIDTH:  return APB_DATA_W'(cols_reg);
        REG_ACTIVE_HEIGHT: return APB_DATA_W'(rows_reg);
        default:           return '0;
      endcase
    endfunction

    // count recent neighbours in the clipped window, then store the event at its pixel
    function void note_event(logic [63:0] ts, logic [8:0] c, logic [8:0] r, logic p);
      int          cols, rows, rad, ci, ri, x, y, n;
      int unsigned hits;
      logic [63:0] age;
      cols = limit(cols_reg, COLS_MAX);
      rows = limit(rows_reg, ROWS_MAX);
      rad  = limit(radius, RADIUS_MAX);
      ci   = c;
      ri   = r;
      hits = 0;
      events++;
      if (ci >= cols || ri >= rows) begin
        keep_due.push_back(1'b0);
        return;
      end
      for (x = ci - rad; x <= ci + rad; x++) begin
        for (y = ri - rad; y <= ri + rad; y++) begin
          if (x < 0 || x >= cols || y < 0 || y >= rows) continue;
          n = y * COLS_MAX + x;
          // a pixel last written by an off event never counts
          if (!pix_pol[n]) continue;
          if (pol_match && pix_pol[n] != p) continue;
          age = ts - pix_time[n];
          if (age <= 64'(window)) hits++;
        end
      end
      keep_due.push_back(hits >= support);
      n = ri * COLS_MAX + ci;
      pix_pol[n]  = p;
      pix_time[n] = ts;
    endfunction

    function void check_keep(logic k);
      bit due;
      results++;
      if (k === 1'b1) kept++;
      if (keep_due.size() == 0) begin
        $display("%0t: keep result %0b with no event outstanding, expected none", $time, k);
        errors++;
        return;
      end
      due = keep_due.pop_front();
      if (k !== due) begin
        $display("%0t: keep mismatch on event %0d, expected %0b, got %0b",
                 $time, results, due, k);
        errors++;
      end
    endfunction
  endclass

  logic                  clk          = 1'b0;
  logic                  rst_n        = 1'b0;
  logic                  in_valid     = 1'b0;
  logic                  in_stall;
  logic [63:0]           in_timestamp = '0;
  logic [COL_W-1:0]      in_col       = '0;
  logic [ROW_W-1:0]      in_row       = '0;
  logic                  in_polarity  = 1'b0;
  logic                  out_valid;
  logic                  out_stall    = 1'b0;
  logic                  out_keep;
  logic                  cfg_psel     = 1'b0;
  logic                  cfg_penable  = 1'b0;
  logic                  cfg_pwrite   = 1'b0;
  logic [APB_ADDR_W-1:0] cfg_paddr    = '0;
  logic [APB_DATA_W-1:0] cfg_pwdata   = '0;
  logic [APB_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  filter_scoreboard sb = new;

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_cycles   = 0;
  int unsigned settings_done = 1;
  logic [63:0] event_ts      = 64'd1000;

  event_background_activity_filter_core DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_timestamp (in_timestamp),
    .in_col       (in_col),
    .in_row       (in_row),
    .in_polarity  (in_polarity),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_keep     (out_keep),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // result side: check every transaction, stall at random or for a long hold
  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) sb.check_keep(out_keep);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // stop the run when no transaction moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
    $display("testbench failed");
    $finish;
  end

  // offer one event, with random idle cycles first, and wait until it is taken
  task automatic send_event(input logic [63:0] ts, input logic [8:0] c,
                            input logic [8:0] r, input logic p);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_timestamp <= ts;
    in_col       <= c;
    in_row       <= r;
    in_polarity  <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_event(ts, c, r, p);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.keep_due.size() != 0) @(posedge clk);
  endtask

  // register write followed by a read back of the same register
  task automatic write_reg(input reg_index_t idx, input logic [APB_DATA_W-1:0] v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    sb.set_reg(idx, v);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== sb.reg_value(idx)) begin
      $display("%0t: read back of register %s, expected %0h, got %0h",
               $time, idx.name(), sb.reg_value(idx), cfg_prdata);
      sb.errors++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  function automatic logic [APB_DATA_W-1:0] pick_size();
    case ($urandom_range(0, 3))
      0:       return 1023;
      1:       return 512;
      2:       return $urandom_range(1, 1023);
      default: return $urandom_range(1, 48);
    endcase
  endfunction

  // fresh random filter settings, every register written
  task automatic pick_settings();
    logic [APB_DATA_W-1:0] support_v, window_v;
    case ($urandom_range(0, 5))
      0:       support_v = 0;
      1:       support_v = 49;
      2:       support_v = 63;
      default: support_v = $urandom_range(1, 5);
    endcase
    case ($urandom_range(0, 4))
      0:       window_v = 0;
      1:       window_v = 32'h7FFF_FFFF;
      2:       window_v = $urandom_range(0, 32'h7FFF_FFFF);
      default: window_v = $urandom_range(20, 5000);
    endcase
    write_reg(REG_MIN_SUPPORT, support_v);
    write_reg(REG_RADIUS, $urandom_range(0, 3));
    write_reg(REG_TIME_WINDOW, window_v);
    write_reg(REG_USE_POLARITY, $urandom_range(0, 1));
    write_reg(REG_ACTIVE_WIDTH, pick_size());
    write_reg(REG_ACTIVE_HEIGHT, pick_size());
    settings_done++;
  endtask

  // mostly bursts of close events around one spot, the rest scattered noise
  task automatic run_events(input int count);
    int          done_items, burst, k, cols, rows, cx, cy, x, y;
    logic [31:0] step_top;
    done_items = 0;
    cols       = sb.limit(sb.cols_reg, COLS_MAX);
    rows       = sb.limit(sb.rows_reg, ROWS_MAX);
    step_top   = sb.window / 4 + 1;
    while (done_items < count) begin
      if ($urandom_range(0, 99) < 80) begin
        cx = (cols == 0) ? $urandom_range(0, COLS_MAX - 1) : $urandom_range(0, cols - 1);
        cy = (rows == 0) ? $urandom_range(0, ROWS_MAX - 1) : $urandom_range(0, rows - 1);
        // pull some bursts onto the active edges
        if (cols > 0 && $urandom_range(0, 3) == 0) cx = $urandom_range(0, 1) ? 0 : cols - 1;
        if (rows > 0 && $urandom_range(0, 3) == 0) cy = $urandom_range(0, 1) ? 0 : rows - 1;
        burst = $urandom_range(3, 12);
        for (k = 0; k < burst && done_items < count; k++) begin
          x = sb.limit(cx + int'($urandom_range(0, 6)) - 3, COLS_MAX - 1);
          y = sb.limit(cy + int'($urandom_range(0, 6)) - 3, ROWS_MAX - 1);
          if (x < 0) x = 0;
          if (y < 0) y = 0;
          event_ts += $urandom_range(0, step_top);
          send_event(event_ts, x[8:0], y[8:0], 1'($urandom_range(0, 1)));
          done_items++;
        end
      end else begin
        if ($urandom_range(0, 3) == 0) event_ts = {$urandom, $urandom};
        else event_ts += $urandom_range(0, step_top);
        send_event(event_ts, 9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                   1'($urandom_range(0, 1)));
        done_items++;
      end
    end
  endtask

  initial begin : stimulus
    int phase;
    rst_n <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 6;
    recv_idle_pct = 63;

    // reset settings: empty memory, one neighbour, window edge, off events, wrapping time
    send_event(64'd0, 9'd0, 9'd0, 1'b1);
    send_event(64'd5, 9'd1, 9'd0, 1'b1);
    send_event(64'd10005, 9'd1, 9'd1, 1'b0);
    send_event(64'd20006, 9'd0, 9'd1, 1'b1);
    send_event(64'd20006, 9'd0, 9'd1, 1'b1);
    send_event(64'hFFFF_FFFF_FFFF_FFF0, 9'd511, 9'd511, 1'b1);
    send_event(64'd5, 9'd510, 9'd510, 1'b0);

    // widest window and radius, polarity must match, two neighbours needed
    wait_drained();
    write_reg(REG_USE_POLARITY, 1);
    write_reg(REG_TIME_WINDOW, 32'h7FFF_FFFF);
    write_reg(REG_RADIUS, 3);
    write_reg(REG_MIN_SUPPORT, 2);
    settings_done++;
    send_event(64'd100, 9'd300, 9'd300, 1'b1);
    send_event(64'd101, 9'd302, 9'd301, 1'b1);
    send_event(64'd102, 9'd301, 9'd303, 1'b1);
    send_event(64'd103, 9'd300, 9'd302, 1'b0);

    // zero support keeps everything, then zero window with radius zero; sizes saturate
    wait_drained();
    write_reg(REG_RADIUS, 0);
    write_reg(REG_TIME_WINDOW, 0);
    write_reg(REG_MIN_SUPPORT, 0);
    write_reg(REG_ACTIVE_WIDTH, 1023);
    write_reg(REG_ACTIVE_HEIGHT, 1023);
    settings_done++;
    send_event(64'd200, 9'd511, 9'd511, 1'b1);
    send_event(64'd200, 9'd511, 9'd511, 1'b1);
    wait_drained();
    write_reg(REG_MIN_SUPPORT, 1);
    settings_done++;
    send_event(64'd201, 9'd511, 9'd511, 1'b1);
    send_event(64'd201, 9'd511, 9'd511, 1'b1);

    // small active area and unreachable support, then a zero width
    wait_drained();
    write_reg(REG_ACTIVE_WIDTH, 10);
    write_reg(REG_ACTIVE_HEIGHT, 20);
    write_reg(REG_MIN_SUPPORT, 63);
    settings_done++;
    send_event(64'd300, 9'd10, 9'd5, 1'b1);
    send_event(64'd300, 9'd5, 9'd20, 1'b1);
    send_event(64'd300, 9'd9, 9'd19, 1'b1);
    wait_drained();
    write_reg(REG_ACTIVE_WIDTH, 0);
    write_reg(REG_USE_POLARITY, 0);
    settings_done++;
    send_event(64'd301, 9'd0, 9'd0, 1'b1);

    // random phases, idling swapped from phase three, then none from phase six with a long result hold
    for (phase = 0; phase < 9; phase++) begin
      if (phase == 3) begin
        send_idle_pct = 63;
        recv_idle_pct = 6;
      end
      if (phase == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      wait_drained();
      pick_settings();
      if (phase == 6) hold_cycles = HOLD_LONG;
      if (phase == 4) begin
        run_events(30);
        wait_drained();
        run_events(30);
      end else begin
        run_events(60);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.keep_due.size() != 0) begin
      $display("%0t: %0d keep results never arrived", $time, sb.keep_due.size());
      sb.errors++;
    end
    $display("covered %0d events under %0d filter settings, %0d results with %0d kept",
             sb.events, settings_done, sb.results, sb.kept);
    if (sb.errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
